[design/rsds_pkg.sv]
// shared types, constants and the dac drive function of the raster scan stepper
`default_nettype none

package rsds_pkg;

  localparam int COORD_BITS     = 12;
  localparam int DAC_BITS       = 16;
  localparam int DAC_FULL_SCALE = 65535;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [DAC_BITS-1:0] DAC_HALF = DAC_BITS'(DAC_FULL_SCALE / 2);

  localparam logic [COORD_BITS-1:0] LAST_COLUMN_RST  = COORD_BITS'(4095);
  localparam logic [COORD_BITS-1:0] LAST_ROW_RST     = COORD_BITS'(4095);
  localparam logic [COORD_BITS-1:0] FIRST_COLUMN_RST = '0;
  localparam logic [COORD_BITS-1:0] FIRST_ROW_RST    = '0;
  localparam logic [DAC_BITS-1:0]   STEP_GAIN_RST    = DAC_BITS'(1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DAC_BITS-1:0]   dac_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LAST_COLUMN     = 3'd0,
    REG_LAST_ROW        = 3'd1,
    REG_FIRST_COLUMN    = 3'd2,
    REG_FIRST_ROW       = 3'd3,
    REG_SERPENTINE_MODE = 3'd4,
    REG_START_LEFTWARD  = 3'd5,
    REG_STEP_GAIN       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    coord_t last_column;
    coord_t last_row;
    coord_t first_column;
    coord_t first_row;
    logic   serpentine_mode;
    logic   start_leftward;
    dac_t   step_gain;
  } cfg_t;

  // one position step, handed from the step stage to the drive stage
  typedef struct packed {
    coord_t col;
    coord_t row;
    logic   move_x;
    logic   move_y;
    logic   done;
  } step_res_t;

  // half scale plus (coord - (axis_last/2 + 1)) * gain, all modulo 2^16
  function automatic dac_t drive_of(coord_t coord, coord_t axis_last, dac_t gain);
    dac_t centre;
    dac_t offset;
    dac_t prod;
    centre = DAC_BITS'(axis_last >> 1) + DAC_BITS'(1);
    offset = DAC_BITS'(coord) - centre;
    prod   = offset * gain;
    return DAC_HALF + prod;
  endfunction

endpackage

`default_nettype wire

[design/rsds_cfg.sv]
// configuration register file of the raster scan stepper
`default_nettype none

module rsds_cfg
  import rsds_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                          cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.last_column     <= LAST_COLUMN_RST;
      cfg.last_row        <= LAST_ROW_RST;
      cfg.first_column    <= FIRST_COLUMN_RST;
      cfg.first_row       <= FIRST_ROW_RST;
      cfg.serpentine_mode <= 1'b0;
      cfg.start_leftward  <= 1'b0;
      cfg.step_gain       <= STEP_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LAST_COLUMN:     cfg.last_column     <= cfg_data[COORD_BITS-1:0];
        REG_LAST_ROW:        cfg.last_row        <= cfg_data[COORD_BITS-1:0];
        REG_FIRST_COLUMN:    cfg.first_column    <= cfg_data[COORD_BITS-1:0];
        REG_FIRST_ROW:       cfg.first_row       <= cfg_data[COORD_BITS-1:0];
        REG_SERPENTINE_MODE: cfg.serpentine_mode <= cfg_data[0];
        REG_START_LEFTWARD:  cfg.start_leftward  <= cfg_data[0];
        REG_STEP_GAIN:       cfg.step_gain       <= cfg_data[DAC_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/rsds_step.sv]
// position stage: grid position and scan direction, one step per request
`default_nettype none

module rsds_step
  import rsds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic restart,
  output logic      res_valid,
  input  wire logic res_ready,
  output step_res_t res
);

  coord_t col;
  coord_t row;
  logic   leftward;

  coord_t col_next;
  coord_t row_next;
  logic   leftward_next;
  logic   move_x;
  logic   move_y;
  logic   done;
  logic   accept;

  assign in_ready = !res_valid || res_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_next      = col;
    row_next      = row;
    leftward_next = leftward;
    move_x        = 1'b0;
    move_y        = 1'b0;
    done          = 1'b0;
    if (restart) begin
      col_next      = cfg.first_column;
      row_next      = cfg.first_row;
      leftward_next = cfg.start_leftward;
      move_x        = 1'b1;
      move_y        = 1'b1;
    end else if (!cfg.serpentine_mode) begin
      if (col < cfg.last_column) begin
        col_next = col + COORD_BITS'(1);
        move_x   = 1'b1;
      end else if (row < cfg.last_row) begin
        col_next = cfg.first_column;
        row_next = row + COORD_BITS'(1);
        move_x   = 1'b1;
        move_y   = 1'b1;
      end else begin
        done = 1'b1;
      end
    end else if (!leftward) begin
      if (col < cfg.last_column) begin
        col_next = col + COORD_BITS'(1);
        move_x   = 1'b1;
      end else if (row < cfg.last_row) begin
        row_next      = row + COORD_BITS'(1);
        move_y        = 1'b1;
        leftward_next = 1'b1;
      end else begin
        done = 1'b1;
      end
    end else begin
      if (col > cfg.first_column) begin
        col_next = col - COORD_BITS'(1);
        move_x   = 1'b1;
      end else if (row < cfg.last_row) begin
        row_next      = row + COORD_BITS'(1);
        move_y        = 1'b1;
        leftward_next = 1'b0;
      end else begin
        done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      leftward  <= 1'b0;
      res_valid <= 1'b0;
    end else if (accept) begin
      col       <= col_next;
      row       <= row_next;
      leftward  <= leftward_next;
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.col    <= col_next;
      res.row    <= row_next;
      res.move_x <= move_x;
      res.move_y <= move_y;
      res.done   <= done;
    end
  end

  // a finished scan leaves the position where it was
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> col == $past(col) && row == $past(row))
    else $error("position moved on a finished scan");

  // after each accepted request the stage result mirrors the live position
  a_res_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> res.col == col && res.row == row)
    else $error("step result differs from position state");

endmodule

`default_nettype wire

[design/rsds_drive.sv]
// drive stage: dac values of the moved axes and the result register
`default_nettype none

module rsds_drive
  import rsds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      res_valid,
  output logic           res_ready,
  input  wire step_res_t res,
  output logic           out_valid,
  input  wire logic      out_ready,
  output coord_t         pos_x,
  output coord_t         pos_y,
  output dac_t           drive_x,
  output dac_t           drive_y,
  output logic           scan_done
);

  logic take;

  assign res_ready = !out_valid || out_ready;
  assign take      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      drive_x   <= '0;
      drive_y   <= '0;
    end else if (take) begin
      out_valid <= 1'b1;
      if (res.move_x) begin
        drive_x <= drive_of(res.col, cfg.last_column, cfg.step_gain);
      end
      if (res.move_y) begin
        drive_y <= drive_of(res.row, cfg.last_row, cfg.step_gain);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pos_x     <= res.col;
      pos_y     <= res.row;
      scan_done <= res.done;
    end
  end

  // an axis that did not move keeps its dac value
  a_x_held: assert property (@(posedge clk) disable iff (rst)
    take && !res.move_x |=> drive_x == $past(drive_x))
    else $error("x drive changed without x motion");

  a_y_held: assert property (@(posedge clk) disable iff (rst)
    take && !res.move_y |=> drive_y == $past(drive_y))
    else $error("y drive changed without y motion");

endmodule

`default_nettype wire

[design/raster_scan_dac_stepper.sv]
// top level of the raster scan stepper with dac drive outputs
`default_nettype none

// Raster / serpentine scan stepper. Each request on the slave stream either
// restarts the scan (restart = 1: load first_column, first_row and
// start_leftward, recompute both dac values) or advances the probe one grid
// point. Raster mode runs every row rightward and returns x to first_column;
// serpentine mode turns at last_column and at first_column, moving to the
// next row. Past the last row scan_done is set and the position holds. Only
// an axis that moved gets a new dac value: half scale plus
// (coord - (last/2 + 1)) * step_gain, modulo 2^16. Every request gives exactly
// one result. The block takes one request per clock while s_tready is high: the
// first stage updates the position registers (compare and increment), the
// second runs one 16x16 multiply-add per axis into the result register. Each
// stage holds its result only while the stage after it is full and not being
// drained, so with m_tready low the block still takes up to two requests before
// s_tready drops; s_tready follows m_tready combinationally once both stages
// are full. Registers are written through the cfg port (always ready); the
// user must write them only while the block is idle, which the block itself
// does not enforce. Indexes 0..6 are last_column, last_row, first_column,
// first_row, serpentine_mode, start_leftward, step_gain.
module raster_scan_dac_stepper
  import rsds_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // slave stream: one request per step
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [7:0]               s_tdata,   // [0] restart, [7:1] zero
  // master stream: one result per request
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [63:0]                   m_tdata,   // [11:0] pos_x, [23:12] pos_y,
                                                   // [39:24] drive_x, [55:40] drive_y,
                                                   // [56] scan_done, [63:57] zero
  // register write channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  step_res_t res;
  coord_t    pos_x;
  coord_t    pos_y;
  dac_t      drive_x;
  dac_t      drive_y;
  logic      scan_done;

  // scan limits, modes and gain
  rsds_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // position and direction update, registered step result
  rsds_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .restart   (s_tdata[0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // dac values for moved axes, output register
  rsds_drive u_drive (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .drive_x   (drive_x),
    .drive_y   (drive_y),
    .scan_done (scan_done)
  );

  // pack the result fields, lowest field first
  assign m_tdata = {7'd0, scan_done, drive_y, drive_x, pos_y, pos_x};

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the raster scan stepper: stream stimulus, scan predictor, result checks
`timescale 1ns / 1ps

module tb_top;
  import rsds_pkg::*;

  // one result as it sits in m_tdata, pos_x in the lowest bits
  typedef struct packed {
    logic   scan_done;
    dac_t   drive_y;
    dac_t   drive_x;
    coord_t pos_y;
    coord_t pos_x;
  } scan_point_t;

  // tracks probe position and dac holds, and checks each result against the oldest prediction
  class scan_tracker;
    cfg_t        regs;
    coord_t      col;
    coord_t      row;
    logic        leftward;
    dac_t        hold_x;
    dac_t        hold_y;
    scan_point_t expected_points[$];
    int          mismatches;
    int          results_seen;
    int          restarts_seen;
    int          done_seen;

    function new();
      regs.last_column     = LAST_COLUMN_RST;
      regs.last_row        = LAST_ROW_RST;
      regs.first_column    = FIRST_COLUMN_RST;
      regs.first_row       = FIRST_ROW_RST;
      regs.serpentine_mode = 1'b0;
      regs.start_leftward  = 1'b0;
      regs.step_gain       = STEP_GAIN_RST;
      col      = '0;
      row      = '0;
      leftward = 1'b0;
      hold_x   = '0;
      hold_y   = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        REG_LAST_COLUMN:     regs.last_column     = value[COORD_BITS-1:0];
        REG_LAST_ROW:        regs.last_row        = value[COORD_BITS-1:0];
        REG_FIRST_COLUMN:    regs.first_column    = value[COORD_BITS-1:0];
        REG_FIRST_ROW:       regs.first_row       = value[COORD_BITS-1:0];
        REG_SERPENTINE_MODE: regs.serpentine_mode = value[0];
        REG_START_LEFTWARD:  regs.start_leftward  = value[0];
        REG_STEP_GAIN:       regs.step_gain       = value;
        default: ;
      endcase
    endfunction

    // half scale plus signed distance from the axis center times gain, mod 2^16
    function dac_t dac_level(coord_t coord, coord_t axis_last);
      logic [31:0] offset;
      logic [31:0] level;
      offset = 32'(coord) - (32'(axis_last) / 2 + 32'd1);
      level  = 32'(DAC_FULL_SCALE / 2) + offset[15:0] * regs.step_gain;
      return level[15:0];
    endfunction

    function void step_row();
      row    = row + 1'b1;
      hold_y = dac_level(row, regs.last_row);
    endfunction

    function void note_request(logic restart);
      scan_point_t p;
      logic        finished;
      finished = 1'b0;
      if (restart) begin
        col      = regs.first_column;
        row      = regs.first_row;
        leftward = regs.start_leftward;
        hold_x   = dac_level(col, regs.last_column);
        hold_y   = dac_level(row, regs.last_row);
        restarts_seen++;
      end else if (!regs.serpentine_mode) begin
        // raster: run right, then snap back to the first column on the next row
        if (col < regs.last_column) begin
          col    = col + 1'b1;
          hold_x = dac_level(col, regs.last_column);
        end else if (row < regs.last_row) begin
          col    = regs.first_column;
          hold_x = dac_level(col, regs.last_column);
          step_row();
        end else begin
          finished = 1'b1;
        end
      end else if (!leftward) begin
        if (col < regs.last_column) begin
          col    = col + 1'b1;
          hold_x = dac_level(col, regs.last_column);
        end else if (row < regs.last_row) begin
          step_row();
          leftward = 1'b1;
        end else begin
          finished = 1'b1;
        end
      end else begin
        if (col > regs.first_column) begin
          col    = col - 1'b1;
          hold_x = dac_level(col, regs.last_column);
        end else if (row < regs.last_row) begin
          step_row();
          leftward = 1'b0;
        end else begin
          finished = 1'b1;
        end
      end
      if (finished) done_seen++;
      p.pos_x     = col;
      p.pos_y     = row;
      p.drive_x   = hold_x;
      p.drive_y   = hold_y;
      p.scan_done = finished;
      expected_points.push_back(p);
    endfunction

    function void check_result(logic [63:0] data);
      scan_point_t got;
      scan_point_t want;
      got = data[56:0];
      results_seen++;
      if (expected_points.size() == 0) begin
        $error("result %h arrived with no request pending", data);
        mismatches++;
        return;
      end
      want = expected_points.pop_front();
      if (got.pos_x !== want.pos_x) begin
        $error("pos_x expected %0d got %0d", want.pos_x, got.pos_x);
        mismatches++;
      end
      if (got.pos_y !== want.pos_y) begin
        $error("pos_y expected %0d got %0d", want.pos_y, got.pos_y);
        mismatches++;
      end
      if (got.drive_x !== want.drive_x) begin
        $error("drive_x expected %0d got %0d", want.drive_x, got.drive_x);
        mismatches++;
      end
      if (got.drive_y !== want.drive_y) begin
        $error("drive_y expected %0d got %0d", want.drive_y, got.drive_y);
        mismatches++;
      end
      if (got.scan_done !== want.scan_done) begin
        $error("scan_done expected %0d got %0d", want.scan_done, got.scan_done);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [7:0]               s_tdata;   // [0] restart, [7:1] zero
  logic                     m_tvalid;
  logic                     m_tready;
  logic [63:0]              m_tdata;   // [11:0] pos_x, [23:12] pos_y, [39:24] drive_x,
                                       // [55:40] drive_y, [56] scan_done, [63:57] zero
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  scan_tracker tracker;
  bit          calm_tail = 1'b0;   // set for the closing phases: no idling on either side
  int          settings_count = 0;

  raster_scan_dac_stepper dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // every handshake is observed here, register writes and requests ahead of results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready) tracker.note_request(s_tdata[0]);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
    end
  end

  // result side backpressure: random stall bursts, none while calm_tail is set
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // generous bound: a clean run needs well under a tenth of this
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // starts and ends at a falling edge; may open with a random gap while calm_tail is clear
  task automatic send_request(input logic restart);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, restart};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_LAST_COLUMN,     CFG_DATA_BITS'(c.last_column));
    write_reg(REG_LAST_ROW,        CFG_DATA_BITS'(c.last_row));
    write_reg(REG_FIRST_COLUMN,    CFG_DATA_BITS'(c.first_column));
    write_reg(REG_FIRST_ROW,       CFG_DATA_BITS'(c.first_row));
    write_reg(REG_SERPENTINE_MODE, CFG_DATA_BITS'(c.serpentine_mode));
    write_reg(REG_START_LEFTWARD,  CFG_DATA_BITS'(c.start_leftward));
    write_reg(REG_STEP_GAIN,       c.step_gain);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // stop sending and wait out every outstanding result plus the pipeline depth
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic cfg_t make_cfg(int lc, int lr, int fc, int fr, int serp, int left, int gain);
    cfg_t c;
    c.last_column     = coord_t'(lc);
    c.last_row        = coord_t'(lr);
    c.first_column    = coord_t'(fc);
    c.first_row       = coord_t'(fr);
    c.serpentine_mode = serp[0];
    c.start_leftward  = left[0];
    c.step_gain       = dac_t'(gain);
    return c;
  endfunction

  // small grids so scans finish often; wide ones exercise all coordinate bits
  function automatic cfg_t random_cfg(bit wide);
    int lc;
    int lr;
    if (wide) begin
      return make_cfg($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 65535));
    end
    lc = $urandom_range(0, 12);
    lr = $urandom_range(0, 8);
    // first column or row may land past the last one
    return make_cfg(lc, lr, $urandom_range(0, lc + 3), $urandom_range(0, lr + 1),
                    $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 65535));
  endfunction

  // a restart, then mostly steps with an occasional restart mid-scan
  task automatic scan_phase(input int steps, input bit drain_midway);
    send_request(1'b1);
    for (int i = 1; i < steps; i++) begin
      if (drain_midway && i == steps / 2) settle();
      send_request($urandom_range(0, 39) == 0);
    end
  endtask

  initial begin
    tracker   = new();
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LAST_COLUMN;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // steps straight out of reset with the reset register values, then a restart
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);

    // single point grid, full gain: finished on the first step
    settle();
    program_regs(make_cfg(0, 0, 0, 0, 0, 0, 65535));
    send_request(1'b1);
    repeat (2) send_request(1'b0);

    // everything at the top, zero gain, serpentine moving left: finished at once
    settle();
    program_regs(make_cfg(4095, 4095, 4095, 4095, 1, 1, 0));
    send_request(1'b1);
    repeat (2) send_request(1'b0);

    // raster with the first column past the last one: x reloads, y walks down
    settle();
    program_regs(make_cfg(2, 3, 5, 0, 0, 0, 3));
    send_request(1'b1);
    repeat (4) send_request(1'b0);

    // serpentine through the turn at the last column until finished
    settle();
    program_regs(make_cfg(2, 1, 0, 0, 1, 0, 1000));
    send_request(1'b1);
    repeat (6) send_request(1'b0);

    // random phases, idling switched off for the last two
    for (int p = 0; p < 14; p++) begin
      calm_tail = (p >= 12);
      settle();
      program_regs(random_cfg(p % 4 == 3));
      scan_phase(50, p % 3 == 1);
    end

    settle();
    repeat (10) @(negedge clk);
    $display("covered %0d requests, %0d restarts and %0d finished-scan steps, over %0d settings",
             tracker.restarts_seen + tracker.results_seen - tracker.restarts_seen,
             tracker.restarts_seen, tracker.done_seen, settings_count);
    $display("checked %0d results, %0d field mismatches",
             tracker.results_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
